@@ rtl/core/ipf_pkg.sv @@
// Isotope peak flagger package: field widths, register indexes, reset values
// and the configuration bundle shared by the config block, lanes and top level.
// No dependencies.
package ipf_pkg;

	localparam int SPEC_W    = 24;
	localparam int MZ_W      = 29;
	localparam int INTEN_W   = 32;
	localparam int SPACING_W = 20;
	localparam int TOL_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam int DEF_WINDOW_DEPTH = 4;

	// signed width that holds new_mz - old_mz - spacing without overflow
	localparam int ERR_W = MZ_W + 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ANCHOR_MZ        = 3'd0,
		REG_MIN_ANCHOR_INTENSITY = 3'd1,
		REG_SPACING_SINGLE       = 3'd2,
		REG_TOLERANCE_SINGLE     = 3'd3,
		REG_SPACING_DOUBLE       = 3'd4,
		REG_TOLERANCE_DOUBLE     = 3'd5
	} cfg_reg_t;

	localparam logic [MZ_W-1:0]      RST_MIN_ANCHOR_MZ        = 29'd35000000;
	localparam logic [INTEN_W-1:0]   RST_MIN_ANCHOR_INTENSITY = 32'd2000;
	localparam logic [SPACING_W-1:0] RST_SPACING_SINGLE       = 20'd100340;
	localparam logic [TOL_W-1:0]     RST_TOLERANCE_SINGLE     = 17'd500;
	localparam logic [SPACING_W-1:0] RST_SPACING_DOUBLE       = 20'd50017;
	localparam logic [TOL_W-1:0]     RST_TOLERANCE_DOUBLE     = 17'd250;

	typedef struct packed {
		logic [MZ_W-1:0]      min_anchor_mz;
		logic [INTEN_W-1:0]   min_anchor_intensity;
		logic [SPACING_W-1:0] spacing_single;
		logic [TOL_W-1:0]     tolerance_single;
		logic [SPACING_W-1:0] spacing_double;
		logic [TOL_W-1:0]     tolerance_double;
	} cfg_t;

endpackage

@@ rtl/core/ipf_cfg_regs.sv @@
// Isotope peak flagger configuration registers, written through a plain
// write port. Depends on ipf_pkg.
module ipf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ipf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipf_pkg::CFG_DAT_W-1:0]    cfg_data,
	output ipf_pkg::cfg_t                    cfg
);
	import ipf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_anchor_mz        <= RST_MIN_ANCHOR_MZ;
			cfg_q.min_anchor_intensity <= RST_MIN_ANCHOR_INTENSITY;
			cfg_q.spacing_single       <= RST_SPACING_SINGLE;
			cfg_q.tolerance_single     <= RST_TOLERANCE_SINGLE;
			cfg_q.spacing_double       <= RST_SPACING_DOUBLE;
			cfg_q.tolerance_double     <= RST_TOLERANCE_DOUBLE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_ANCHOR_MZ:        cfg_q.min_anchor_mz        <= cfg_data[MZ_W-1:0];
				REG_MIN_ANCHOR_INTENSITY: cfg_q.min_anchor_intensity <= cfg_data[INTEN_W-1:0];
				REG_SPACING_SINGLE:       cfg_q.spacing_single       <= cfg_data[SPACING_W-1:0];
				REG_TOLERANCE_SINGLE:     cfg_q.tolerance_single     <= cfg_data[TOL_W-1:0];
				REG_SPACING_DOUBLE:       cfg_q.spacing_double       <= cfg_data[SPACING_W-1:0];
				REG_TOLERANCE_DOUBLE:     cfg_q.tolerance_double     <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/ipf_lane.sv @@
// Isotope peak flagger compare lane: one window entry against the new peak,
// single and double spacing tests. Depends on ipf_pkg.
module ipf_lane (
	input  logic [ipf_pkg::SPEC_W-1:0] spec_new,
	input  logic [ipf_pkg::MZ_W-1:0]   mz_new,
	input  logic [ipf_pkg::SPEC_W-1:0] spec_old,
	input  logic [ipf_pkg::MZ_W-1:0]   mz_old,
	input  logic                       elig_old,
	input  ipf_pkg::cfg_t              cfg,
	output logic                       hit
);
	import ipf_pkg::*;

	logic signed [ERR_W-1:0] gap;
	logic signed [ERR_W-1:0] err_single;
	logic signed [ERR_W-1:0] err_double;
	logic signed [ERR_W-1:0] tol_single;
	logic signed [ERR_W-1:0] tol_double;
	logic                    near_single;
	logic                    near_double;

	always_comb begin
		gap = $signed({{(ERR_W-MZ_W){1'b0}}, mz_new}) -
		      $signed({{(ERR_W-MZ_W){1'b0}}, mz_old});
		err_single = gap - $signed({{(ERR_W-SPACING_W){1'b0}}, cfg.spacing_single});
		err_double = gap - $signed({{(ERR_W-SPACING_W){1'b0}}, cfg.spacing_double});
		tol_single = $signed({{(ERR_W-TOL_W){1'b0}}, cfg.tolerance_single});
		tol_double = $signed({{(ERR_W-TOL_W){1'b0}}, cfg.tolerance_double});
		// |err| < tol  <=>  -tol < err < tol
		near_single = (err_single < tol_single) && (err_single > -tol_single);
		near_double = (err_double < tol_double) && (err_double > -tol_double);
		hit = elig_old && (spec_old == spec_new) && (near_single || near_double);
	end

endmodule

@@ rtl/core/isotope_peak_flagger.sv @@
// Isotope peak flagger top level: input register, peak window, compare lanes
// and result register. Depends on ipf_pkg, ipf_cfg_regs, ipf_lane.
// A word passes the input register, then the result register; one word per
// cycle unless out_stall holds the result. The window shift and all lane
// compares complete between the input and result registers. Reset clears the
// window eligibility and valids and restores the register defaults.
module isotope_peak_flagger #(
	parameter int WINDOW_DEPTH = ipf_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ipf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ipf_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ipf_pkg::SPEC_W-1:0]      spectrum_id,
	input  logic [ipf_pkg::MZ_W-1:0]        peak_mz,
	input  logic [ipf_pkg::INTEN_W-1:0]     peak_intensity,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_isotope
);
	import ipf_pkg::*;

	cfg_t cfg;

	logic              valid_s1;
	logic [SPEC_W-1:0] spec_s1;
	logic [MZ_W-1:0]   mz_s1;
	logic              elig_s1;
	logic              advance;

	logic [WINDOW_DEPTH-1:0][SPEC_W-1:0] win_spec_q;
	logic [WINDOW_DEPTH-1:0][MZ_W-1:0]   win_mz_q;
	logic [WINDOW_DEPTH-1:0]             win_elig_q;
	logic [WINDOW_DEPTH-1:0]             lane_hit;

	logic valid_s2;
	logic hit_s2;

	ipf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// eligibility taken with the thresholds in force at entry
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			spec_s1 <= spectrum_id;
			mz_s1   <= peak_mz;
			elig_s1 <= (peak_mz > cfg.min_anchor_mz) &&
			           (peak_intensity > cfg.min_anchor_intensity);
		end
	end

	genvar k;
	generate
		for (k = 0; k < WINDOW_DEPTH; k++) begin : g_lane
			ipf_lane u_lane (
				.spec_new (spec_s1),
				.mz_new   (mz_s1),
				.spec_old (win_spec_q[k]),
				.mz_old   (win_mz_q[k]),
				.elig_old (win_elig_q[k]),
				.cfg      (cfg),
				.hit      (lane_hit[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_elig_q <= '0;
		end else if (advance) begin
			win_elig_q[0] <= elig_s1;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				win_elig_q[i] <= win_elig_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_spec_q[0] <= spec_s1;
			win_mz_q[0]   <= mz_s1;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				win_spec_q[i] <= win_spec_q[i-1];
				win_mz_q[i]   <= win_mz_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2 <= |lane_hit;
		end
	end

	assign out_valid  = valid_s2;
	assign is_isotope = hit_s2;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

	a_held_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(mz_s1) && $stable(spec_s1))
		else $error("held word changed while stalled");

	a_empty_window_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (win_elig_q == '0) |=> !hit_s2)
		else $error("hit flagged with no eligible window entry");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted word lost");

endmodule
